FILE: design/pmcp_pkg.sv
// Shared constants, command and status types of the pitch mark correlation picker.
package pmcp_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MAX_PERIOD  = 1024;
    localparam int PER_W       = 11;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = 34;
    localparam int PROD2_W     = 2 * SAMPLE_BITS;
    localparam int NUM_W       = 42;
    localparam int MAG_W       = 41;
    localparam int PROD_W      = 123;
    localparam int MCNT_W      = $clog2(MAG_W + 1);

    localparam logic [1:0] MS_CUR_SQ  = 2'd0;
    localparam logic [1:0] MS_LEFT    = 2'd1;
    localparam logic [1:0] MS_BEST_SQ = 2'd2;
    localparam logic [1:0] MS_RIGHT   = 2'd3;

    typedef struct packed {
        logic       wr;
        logic       req_load;
        logic       peak_run;
        logic       cand_first;
        logic       cand_next;
        logic       acc_run;
        logic       take;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic peak_done;
        logic can_refine;
        logic acc_done;
        logic cand_last;
        logic have;
        logic sgn_diff;
        logic sgn_gt;
        logic cur_zero;
        logic cur_pos;
        logic mul_done;
        logic mag_gt;
        logic mag_lt;
    } t_sts;

endpackage

FILE: design/pitch_mark_correlation_picker.sv
// Top level of the pitch mark correlation picker.
// Samples are accepted while no mark request is in progress, and may then arrive back to back.
// A mark request runs a peak scan over a window of W samples and then, for each of up to
// 2*max(1,P/4)+1 candidates, correlation sums over P sample pairs on the two-port store
// and up to four products on the bit-serial score multiplier.
// Reset is synchronous and immediate; a fill count makes unwritten store entries read as zero.
module pitch_mark_correlation_picker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic signed [15:0]            i_sample_value,
    input  logic signed [31:0]            i_end_index,
    input  logic [pmcp_pkg::PER_W-1:0]    i_period,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_mark_index,
    output logic                          o_was_refined
);

    pmcp_pkg::t_cmd w_cmd;
    pmcp_pkg::t_sts w_sts;

    pmcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_req_type (i_req_type),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    pmcp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample_value (i_sample_value),
        .i_end_index    (i_end_index),
        .i_period       (i_period),
        .o_mark_index   (o_mark_index),
        .o_was_refined  (o_was_refined)
    );

endmodule

FILE: design/pmcp_ctrl.sv
// Controller state machine: handshakes and sequencing of peak scan and refinement.
module pmcp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_req_type,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    output pmcp_pkg::t_cmd  o_cmd,
    input  pmcp_pkg::t_sts  i_sts
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PEAK = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_M0   = 4'd5;
    localparam logic [3:0] S_M1   = 4'd6;
    localparam logic [3:0] S_M2   = 4'd7;
    localparam logic [3:0] S_M3   = 4'd8;
    localparam logic [3:0] S_NEXT = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       w_acc;

    assign o_stall = (r_state != S_IDLE) || (r_ovalid && i_req_type);
    assign o_valid = r_ovalid;
    assign w_acc   = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_req_type) begin
                        o_cmd.req_load = 1'b1;
                        n_state        = S_PEAK;
                    end else begin
                        o_cmd.wr = 1'b1;
                    end
                end
            end
            S_PEAK: begin
                o_cmd.peak_run = 1'b1;
                if (i_sts.peak_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.can_refine) begin
                    o_cmd.cand_first = 1'b1;
                    n_state          = S_ACC;
                end else begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_ACC: begin
                o_cmd.acc_run = 1'b1;
                if (i_sts.acc_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (!i_sts.have || i_sts.sgn_diff) begin
                    o_cmd.take = !i_sts.have || i_sts.sgn_gt;
                    n_state    = S_NEXT;
                end else if (i_sts.cur_zero) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = pmcp_pkg::MS_CUR_SQ;
                    n_state         = S_M0;
                end
            end
            S_M0: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = pmcp_pkg::MS_LEFT;
                    n_state         = S_M1;
                end
            end
            S_M1: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = pmcp_pkg::MS_BEST_SQ;
                    n_state         = S_M2;
                end
            end
            S_M2: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = pmcp_pkg::MS_RIGHT;
                    n_state         = S_M3;
                end
            end
            S_M3: begin
                if (i_sts.mul_done) begin
                    o_cmd.take = i_sts.cur_pos ? i_sts.mag_gt : i_sts.mag_lt;
                    n_state    = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_sts.cand_last) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.cand_next = 1'b1;
                    n_state         = S_ACC;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.out_load) begin
            n_ovalid = 1'b1;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

FILE: design/pmcp_dp.sv
// Datapath: sample ring store, peak scan, correlation sums and serial score compare.
module pmcp_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pmcp_pkg::t_cmd                        i_cmd,
    output pmcp_pkg::t_sts                        o_sts,
    input  logic signed [15:0]                    i_sample_value,
    input  logic signed [31:0]                    i_end_index,
    input  logic [pmcp_pkg::PER_W-1:0]            i_period,
    output logic signed [31:0]                    o_mark_index,
    output logic                                  o_was_refined
);

    localparam int AW = pmcp_pkg::ADDR_W;
    localparam int IW = pmcp_pkg::IDX_W;
    localparam int PW = pmcp_pkg::PER_W;
    localparam int SB = pmcp_pkg::SAMPLE_BITS;
    localparam int NW = pmcp_pkg::NUM_W;
    localparam int MW = pmcp_pkg::MAG_W;
    localparam int XW = pmcp_pkg::PROD_W;

    logic signed [SB-1:0] r_mem [pmcp_pkg::STORE_DEPTH];

    logic [31:0]          r_wcnt;
    logic                 r_full;
    logic signed [31:0]   r_pred;
    logic [PW-1:0]        r_p;
    logic signed [IW-1:0] r_ridx, r_hi, r_pidx, r_found, r_cand, r_cend, r_bmark;
    logic signed [SB-1:0] r_best_v;
    logic                 r_pfirst;
    logic [AW-1:0]        r_aa, r_ab;
    logic signed [SB-1:0] r_qa, r_qb;
    logic                 r_oka, r_okb;
    logic                 r_v1, r_v2;
    logic signed [pmcp_pkg::PROD2_W-1:0] r_pab, w_pab, w_pbb_s;
    logic [pmcp_pkg::PROD2_W-1:0]        r_pbb;
    logic [PW-1:0]        r_i;
    logic signed [NW-1:0] r_num, r_bnum;
    logic [MW-1:0]        r_en, r_ben;
    logic                 r_have, r_refined;
    logic [XW-1:0]        r_ma, r_mp, r_l;
    logic [MW-1:0]        r_mb;
    logic [pmcp_pkg::MCNT_W-1:0] r_mcnt;
    logic signed [31:0]   r_mark;
    logic                 r_orefined;

    logic [PW-1:0]        w_pc, w_q4, w_rq4, w_rad;
    logic signed [IW-1:0] w_pred_x, w_end_x, w_pcx, w_q4x, w_lo, w_hi;
    logic signed [IW-1:0] w_px, w_radx, w_2px, w_ncand, w_fa, w_cb, w_mark, w_np;
    logic [AW-1:0]        w_ra, w_rb;
    logic                 w_pk_issue, w_ac_issue;
    logic signed [SB-1:0] w_da, w_db;
    logic signed [NW-1:0] w_abs_c, w_abs_b;
    logic [MW-1:0]        w_mag_c, w_mag_b;
    logic [1:0]           w_rank_c, w_rank_b;

    always_comb begin
        if (i_period == '0) begin
            w_pc = PW'(1);
        end else if (i_period > PW'(pmcp_pkg::MAX_PERIOD)) begin
            w_pc = PW'(pmcp_pkg::MAX_PERIOD);
        end else begin
            w_pc = i_period;
        end
    end

    assign w_q4     = w_pc >> 2;
    assign w_pred_x = IW'(r_pred);
    assign w_end_x  = IW'(i_end_index);
    assign w_pcx    = signed'(IW'(w_pc));
    assign w_q4x    = signed'(IW'(w_q4));
    assign w_lo     = (r_pred > 0) ? (w_pred_x - w_q4x) : (w_end_x - w_pcx);
    assign w_hi     = (r_pred > 0) ? (w_pred_x + w_q4x) : w_end_x;

    assign w_rq4  = r_p >> 2;
    assign w_rad  = (w_rq4 == '0) ? PW'(1) : w_rq4;
    assign w_px   = signed'(IW'(r_p));
    assign w_radx = signed'(IW'(w_rad));
    assign w_2px  = signed'(IW'({r_p, 1'b0}));
    assign w_ncand = i_cmd.cand_first ? (r_found - w_radx) : (r_cand + IW'(1));
    assign w_fa   = r_found - w_px;
    assign w_cb   = w_ncand - w_px;
    assign w_mark = r_refined ? r_bmark : r_found;
    assign w_np   = w_mark + w_px;

    assign w_pk_issue = i_cmd.peak_run && (r_ridx <= r_hi);
    assign w_ac_issue = i_cmd.acc_run && (r_i != r_p);
    assign w_ra = w_pk_issue ? r_ridx[AW-1:0] : r_aa;
    assign w_rb = r_ab;
    assign w_da = r_oka ? r_qa : '0;
    assign w_db = r_okb ? r_qb : '0;
    assign w_pab   = w_da * w_db;
    assign w_pbb_s = w_db * w_db;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[r_wcnt[AW-1:0]] <= SB'(i_sample_value);
        end
        r_qa  <= r_mem[w_ra];
        r_qb  <= r_mem[w_rb];
        r_oka <= r_full || (w_ra < r_wcnt[AW-1:0]);
        r_okb <= r_full || (w_rb < r_wcnt[AW-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt <= '0;
            r_full <= 1'b0;
            r_pred <= -32'sd1;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_mcnt <= '0;
        end else begin
            if (i_cmd.wr) begin
                r_wcnt <= r_wcnt + 32'd1;
                if (r_wcnt[AW-1:0] == '1) begin
                    r_full <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_pred <= w_np[31:0];
            end
            r_v1 <= w_pk_issue || w_ac_issue;
            r_v2 <= r_v1 && i_cmd.acc_run;
            if (i_cmd.mul_start) begin
                r_mcnt <= pmcp_pkg::MCNT_W'(MW);
            end else if (r_mcnt != '0) begin
                r_mcnt <= r_mcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_p       <= w_pc;
            r_ridx    <= w_lo;
            r_hi      <= w_hi;
            r_pfirst  <= 1'b1;
            r_refined <= 1'b0;
        end
        if (w_pk_issue) begin
            r_ridx <= r_ridx + IW'(1);
            r_pidx <= r_ridx;
        end
        if (r_v1 && i_cmd.peak_run && (r_pfirst || (w_da > r_best_v))) begin
            r_best_v <= w_da;
            r_found  <= r_pidx;
            r_pfirst <= 1'b0;
        end
        if (i_cmd.cand_first) begin
            r_cend    <= r_found + w_radx;
            r_have    <= 1'b0;
            r_refined <= 1'b1;
        end
        if (i_cmd.cand_first || i_cmd.cand_next) begin
            r_cand <= w_ncand;
            r_i    <= '0;
            r_num  <= '0;
            r_en   <= '0;
            r_aa   <= w_fa[AW-1:0];
            r_ab   <= w_cb[AW-1:0];
        end
        if (w_ac_issue) begin
            r_aa <= r_aa + 1'b1;
            r_ab <= r_ab + 1'b1;
            r_i  <= r_i + 1'b1;
        end
        r_pab <= w_pab;
        r_pbb <= unsigned'(w_pbb_s);
        if (r_v2) begin
            r_num <= r_num + NW'(r_pab);
            r_en  <= r_en + MW'(r_pbb);
        end
        if (i_cmd.take) begin
            r_bnum  <= r_num;
            r_ben   <= r_en;
            r_bmark <= r_cand;
            r_have  <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_mark     <= w_mark[31:0];
            r_orefined <= r_refined;
        end
    end

    assign w_abs_c = r_num[NW-1] ? -r_num : r_num;
    assign w_abs_b = r_bnum[NW-1] ? -r_bnum : r_bnum;
    assign w_mag_c = w_abs_c[MW-1:0];
    assign w_mag_b = w_abs_b[MW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mp <= '0;
            case (i_cmd.mul_sel)
                pmcp_pkg::MS_CUR_SQ: begin
                    r_ma <= XW'(w_mag_c);
                    r_mb <= w_mag_c;
                end
                pmcp_pkg::MS_LEFT: begin
                    r_ma <= r_mp;
                    r_mb <= r_ben;
                end
                pmcp_pkg::MS_BEST_SQ: begin
                    r_ma <= XW'(w_mag_b);
                    r_mb <= w_mag_b;
                    r_l  <= r_mp;
                end
                default: begin
                    r_ma <= r_mp;
                    r_mb <= r_en;
                end
            endcase
        end else if (r_mcnt != '0) begin
            if (r_mb[0]) begin
                r_mp <= r_mp + r_ma;
            end
            r_ma <= r_ma << 1;
            r_mb <= r_mb >> 1;
        end
    end

    assign w_rank_c = (r_num == '0) ? 2'd1 : (r_num[NW-1] ? 2'd0 : 2'd2);
    assign w_rank_b = (r_bnum == '0) ? 2'd1 : (r_bnum[NW-1] ? 2'd0 : 2'd2);

    always_comb begin
        o_sts.peak_done  = (r_ridx > r_hi) && !r_v1;
        o_sts.can_refine = (r_wcnt >= 32'(w_2px)) && (r_found >= w_2px);
        o_sts.acc_done   = (r_i == r_p) && !r_v1 && !r_v2;
        o_sts.cand_last  = (r_cand == r_cend);
        o_sts.have       = r_have;
        o_sts.sgn_diff   = (w_rank_c != w_rank_b);
        o_sts.sgn_gt     = (w_rank_c > w_rank_b);
        o_sts.cur_zero   = (w_rank_c == 2'd1);
        o_sts.cur_pos    = (w_rank_c == 2'd2);
        o_sts.mul_done   = (r_mcnt == '0);
        o_sts.mag_gt     = (r_l > r_mp);
        o_sts.mag_lt     = (r_l < r_mp);
    end

    assign o_mark_index  = r_mark;
    assign o_was_refined = r_orefined;

endmodule

FILE: design/pmcp_checker.sv
// Port checker for the pitch mark correlation picker and its bind.
module pmcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_req_type,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_mark_index
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Result valid after reset.");

    a_request_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_req_type) |=> o_stall)
        else $error("Mark request transfer did not make the block busy.");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("Result appeared without a request in progress.");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_mark_index)))
        else $error("Stalled result changed.");

endmodule

bind pitch_mark_correlation_picker pmcp_checker u_pmcp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_req_type   (i_req_type),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_mark_index (o_mark_index)
);
